### rtl/core/mk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mk_pkg
// Shared types, constants and the Morse code table for the keyer core.
// ----------------------------------------------------------------------------
package mk_pkg;

  localparam int unsigned TickW    = 16;
  localparam int unsigned CharW    = 8;
  localparam int unsigned CountW   = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = TickW;

  localparam logic [TickW-1:0] DotTicksRst  = 16'd1024;
  localparam logic [TickW-1:0] DashTicksRst = 16'd3200;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharNone  = 8'h00;
  localparam int unsigned      RomDepth  = 36;
  localparam int unsigned      RomIdxW   = $clog2(RomDepth);
  localparam int unsigned      DigitBase = 26;

  typedef enum logic [1:0] {
    PH_MARK     = 2'd0,
    PH_GAP      = 2'd1,
    PH_ELEM_END = 2'd2,
    PH_CHAR_END = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOT_TICKS  = 1'b0,
    CFG_DASH_TICKS = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_SEND = 1'b1
  } kind_e;

  typedef struct packed {
    logic             hit;
    logic [CharW-1:0] code;
  } rom_lookup_t;

  // Elements from bit 7 down (1 = dot, 0 = dash), element count in bits 2..0.
  localparam logic [CharW-1:0] MORSE_ROM [RomDepth] = '{
    8'h82, 8'h74, 8'h54, 8'h63, 8'h81, 8'hD4, 8'h23, 8'hF4, 8'hC2, 8'h84,
    8'h43, 8'hB4, 8'h02, 8'h42, 8'h03, 8'h94, 8'h24, 8'hA3, 8'hE3, 8'h01,
    8'hC3, 8'hE4, 8'h83, 8'h64, 8'h44, 8'h34,
    8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5, 8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D
  };

  function automatic rom_lookup_t morse_lookup(input logic [CharW-1:0] c);
    rom_lookup_t            r;
    logic [RomIdxW-1:0]     idx;
    logic [CharW-1:0]       off;
    r   = '0;
    idx = '0;
    off = '0;
    if (c >= "A" && c <= "Z") begin
      off   = c - 8'("A");
      idx   = off[RomIdxW-1:0];
      r.hit = 1'b1;
    end else if (c >= "a" && c <= "z") begin
      off   = c - 8'("a");
      idx   = off[RomIdxW-1:0];
      r.hit = 1'b1;
    end else if (c >= "0" && c <= "9") begin
      off   = c - 8'("0") + 8'(DigitBase);
      idx   = off[RomIdxW-1:0];
      r.hit = 1'b1;
    end else if (c == CharSpace) begin
      off   = 8'("e") - 8'("a");
      idx   = off[RomIdxW-1:0];
      r.hit = 1'b1;
    end
    r.code = r.hit ? MORSE_ROM[idx] : '0;
    return r;
  endfunction

endpackage : mk_pkg
`default_nettype wire

### rtl/core/mk_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mk_in_if / mk_out_if
// Valid/ready channels carrying keyer requests and keyer status.
// ----------------------------------------------------------------------------
interface mk_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface : mk_in_if

interface mk_out_if;
  logic       valid;
  logic       ready;
  logic       key_on;
  logic [7:0] busy_char;
  logic       accepted;

  modport source (output valid, key_on, busy_char, accepted, input ready);
  modport sink   (input valid, key_on, busy_char, accepted, output ready);
endinterface : mk_out_if
`default_nettype wire

### rtl/core/morse_keyer_core.sv
// A transaction on in_i is either a time tick or a character send; every accepted
// transaction yields exactly one status transaction on out_o (key level, character
// in progress, send accepted). The core takes one transaction per clock: state is
// updated in the accepting cycle and the status lands in an output register, valid
// in the next cycle; a new request is taken whenever that register is empty or being
// drained in the same cycle. The user must write dot_ticks and dash_ticks through
// cfg_we_i/cfg_idx_i/cfg_data_i only while the core is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_keyer_core
// Single-character Morse keyer: table lookup, element sequencer, tick timer.
// ----------------------------------------------------------------------------
module morse_keyer_core
  import mk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  mk_in_if.sink                    in_i,
  mk_out_if.source                 out_o
);

  logic [TickW-1:0]  dot_ticks_q, dash_ticks_q;
  logic [CharW-1:0]  cur_char_q, cur_char_d;
  logic [CharW-1:0]  pattern_q, pattern_d;
  logic [CountW-1:0] elem_left_q, elem_left_d;
  phase_e            phase_q, phase_d;
  logic [TickW-1:0]  wait_q, wait_d, wait_dec;
  logic              key_q, key_d;
  logic              accepted_d;

  logic              out_valid_q;
  logic              out_key_q;
  logic [CharW-1:0]  out_char_q;
  logic              out_acc_q;

  logic              in_acc;
  rom_lookup_t       lookup;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign lookup     = morse_lookup(in_i.char_code);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q  <= DotTicksRst;
      dash_ticks_q <= DashTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DOT_TICKS:  dot_ticks_q  <= cfg_data_i;
        CFG_DASH_TICKS: dash_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;

  always_comb begin
    cur_char_d  = cur_char_q;
    pattern_d   = pattern_q;
    elem_left_d = elem_left_q;
    phase_d     = phase_q;
    wait_d      = wait_q;
    key_d       = key_q;
    accepted_d  = 1'b0;
    if (kind_e'(in_i.kind) == KIND_SEND) begin
      if (lookup.hit) begin
        cur_char_d  = in_i.char_code;
        pattern_d   = lookup.code;
        elem_left_d = lookup.code[CountW-1:0];
        phase_d     = PH_MARK;
        accepted_d  = 1'b1;
      end
    end else if (cur_char_q != CharNone) begin
      wait_d = wait_dec;
      if (wait_dec == '0) begin
        unique case (phase_q)
          PH_MARK: begin
            pattern_d   = {pattern_q[CharW-2:0], 1'b0};
            elem_left_d = elem_left_q - 1'b1;
            if (cur_char_q != CharSpace) key_d = 1'b1;
            phase_d     = PH_GAP;
            wait_d      = pattern_q[CharW-1] ? dot_ticks_q : dash_ticks_q;
          end
          PH_GAP: begin
            key_d   = 1'b0;
            phase_d = PH_ELEM_END;
            wait_d  = dot_ticks_q;
          end
          PH_ELEM_END: begin
            if (elem_left_q == '0) begin
              phase_d = PH_CHAR_END;
              wait_d  = dash_ticks_q;
            end else begin
              phase_d = PH_MARK;
            end
          end
          PH_CHAR_END: begin
            phase_d    = PH_MARK;
            cur_char_d = CharNone;
          end
          default: phase_d = PH_MARK;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_char_q  <= CharNone;
      pattern_q   <= '0;
      elem_left_q <= '0;
      phase_q     <= PH_MARK;
      wait_q      <= '0;
      key_q       <= 1'b0;
    end else if (in_acc) begin
      cur_char_q  <= cur_char_d;
      pattern_q   <= pattern_d;
      elem_left_q <= elem_left_d;
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      key_q       <= key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_key_q  <= key_d;
      out_char_q <= cur_char_d;
      out_acc_q  <= accepted_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.key_on    = out_key_q;
  assign out_o.busy_char = out_char_q;
  assign out_o.accepted  = out_acc_q;

  // idle character always parks the sequencer at mark
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_char_q == CharNone) |-> (phase_q == PH_MARK))
    else $error("idle with sequencer away from mark");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted transaction produced no result");

  a_reject_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.kind && !lookup.hit) |=>
      ($stable(cur_char_q) && $stable(pattern_q) && $stable(wait_q)))
    else $error("unrecognized character changed state");

  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_acc_q) |-> (out_char_q != CharNone))
    else $error("accepted send reported idle");

endmodule : morse_keyer_core
`default_nettype wire

### tb/morse_keyer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_keyer_core_test
// Self-checking bench for the Morse keyer core. A short table of directed
// transactions (idle ticks, ignored characters, every table range, space,
// sends over a character in progress) is followed by random character
// bursts under several dot/dash timings, extremes included. Each status
// transaction is checked against a fixed row value or a cycle-free keyer
// model, with random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module morse_keyer_core_test;
  import mk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 160;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [7:0]  SPACE_CODE  = 8'h20;

  typedef struct packed {
    logic       key_on;
    logic [7:0] busy_char;
    logic       accepted;
  } keyer_status_t;

  typedef struct packed {
    logic          fixed;
    keyer_status_t val;
  } status_hint_t;

  typedef struct packed {
    kind_e         kind;
    logic [7:0]    code;
    logic          fixed;
    keyer_status_t val;
  } dir_row_t;

  // A..Z then 0..9; elements from bit 7 down (1 = dot), count in bits 2..0
  localparam logic [7:0] CW_TABLE [36] = '{
    8'h82, 8'h74, 8'h54, 8'h63, 8'h81, 8'hD4, 8'h23, 8'hF4, 8'hC2, 8'h84,
    8'h43, 8'hB4, 8'h02, 8'h42, 8'h03, 8'h94, 8'h24, 8'hA3, 8'hE3, 8'h01,
    8'hC3, 8'hE4, 8'h83, 8'h64, 8'h44, 8'h34,
    8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5, 8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D
  };

  localparam int unsigned DIR_COUNT = 24;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{KIND_TICK, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h1F, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h21, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h2F, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h3A, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h40, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h5B, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h60, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h7B, 1'b1, '{1'b0, 8'h00, 1'b0}},
    '{KIND_SEND, 8'h41, 1'b1, '{1'b0, 8'h41, 1'b1}},
    '{KIND_TICK, 8'hFF, 1'b0, '0},
    '{KIND_TICK, 8'h00, 1'b0, '0},
    '{KIND_SEND, 8'h7A, 1'b0, '0},
    '{KIND_TICK, 8'h55, 1'b0, '0},
    '{KIND_SEND, 8'h5A, 1'b0, '0},
    '{KIND_SEND, 8'h30, 1'b0, '0},
    '{KIND_TICK, 8'hAA, 1'b0, '0},
    '{KIND_SEND, 8'h39, 1'b0, '0},
    '{KIND_SEND, 8'h20, 1'b0, '0},
    '{KIND_TICK, 8'h00, 1'b0, '0},
    '{KIND_TICK, 8'h00, 1'b0, '0},
    '{KIND_SEND, 8'h61, 1'b0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  mk_in_if  in_if ();
  mk_out_if out_if ();

  morse_keyer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // keyer model state
  logic [15:0] dot_len    = 16'd1024;
  logic [15:0] dash_len   = 16'd3200;
  logic [7:0]  cur_char   = '0;
  logic [7:0]  pattern    = '0;
  logic [2:0]  elems_left = '0;
  phase_e      step_phase = PH_MARK;
  logic [15:0] wait_cnt   = '0;
  logic        key_down   = 1'b0;

  keyer_status_t status_q [$];
  status_hint_t  hint_q [$];
  int unsigned   fail_count = 0;
  int unsigned   busy_items = 0;
  int unsigned   rcv_count  = 0;
  logic          quiet      = 1'b0;
  logic          held       = 1'b0;

  function automatic keyer_status_t advance_keyer(input logic kind, input logic [7:0] c);
    keyer_status_t st;
    logic          hit;
    logic [7:0]    idx;
    logic          is_dot;
    st  = '0;
    hit = 1'b1;
    idx = '0;
    if (kind == KIND_SEND) begin
      if (c >= 8'h41 && c <= 8'h5A) idx = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) idx = c - 8'h61;
      else if (c >= 8'h30 && c <= 8'h39) idx = c - 8'h30 + 8'd26;
      else if (c == SPACE_CODE) idx = 8'd4;  // silent E
      else hit = 1'b0;
      if (hit) begin
        cur_char    = c;
        pattern     = CW_TABLE[idx];
        elems_left  = CW_TABLE[idx][2:0];
        step_phase  = PH_MARK;
        st.accepted = 1'b1;
      end
    end else if (cur_char != '0) begin
      if (wait_cnt != '0) wait_cnt = wait_cnt - 16'd1;
      if (wait_cnt == '0) begin
        case (step_phase)
          PH_MARK: begin
            is_dot     = pattern[7];
            pattern    = pattern << 1;
            elems_left = elems_left - 3'd1;
            if (cur_char != SPACE_CODE) key_down = 1'b1;
            step_phase = PH_GAP;
            wait_cnt   = is_dot ? dot_len : dash_len;
          end
          PH_GAP: begin
            key_down   = 1'b0;
            step_phase = PH_ELEM_END;
            wait_cnt   = dot_len;
          end
          PH_ELEM_END: begin
            if (elems_left == '0) begin
              step_phase = PH_CHAR_END;
              wait_cnt   = dash_len;
            end else begin
              step_phase = PH_MARK;
            end
          end
          default: begin
            step_phase = PH_MARK;
            cur_char   = '0;
          end
        endcase
      end
    end
    st.key_on    = key_down;
    st.busy_char = cur_char;
    return st;
  endfunction

  keyer_status_t want;
  keyer_status_t got;
  keyer_status_t predicted;
  status_hint_t  hint;
  logic          was_busy;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DOT_TICKS) dot_len = cfg_data_i;
        else dash_len = cfg_data_i;
      end
      if (in_if.valid && in_if.ready) begin
        was_busy  = (cur_char != '0);
        predicted = advance_keyer(in_if.kind, in_if.char_code);
        if (predicted.accepted || (in_if.kind == KIND_TICK && was_busy)) busy_items++;
        hint = hint_q.pop_front();
        status_q.push_back(hint.fixed ? hint.val : predicted);
      end
      if (out_if.valid && out_if.ready) begin
        rcv_count++;
        got = '{out_if.key_on, out_if.busy_char, out_if.accepted};
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected status transaction: key=%0b char=%02h acc=%0b",
                     got.key_on, got.busy_char, got.accepted);
        end else begin
          want = status_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("status mismatch #%0d: expected key=%0b char=%02h acc=%0b,",
                       rcv_count, want.key_on, want.busy_char, want.accepted,
                       " got key=%0b char=%02h acc=%0b",
                       got.key_on, got.busy_char, got.accepted);
          end
        end
      end
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int unsigned k;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && rcv_count >= 200) begin
        out_if.ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        held = 1'b1;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic push_item(input kind_e kind, input logic [7:0] code,
                           input logic fixed, input keyer_status_t val);
    while (!quiet && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    hint_q.push_back('{fixed, val});
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.char_code <= code;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic push_tick();
    push_item(KIND_TICK, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  task automatic drain_status();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0 || hint_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    logic [7:0]  off;
    r   = $urandom_range(62);
    off = 8'(r);
    if (r < 26) return 8'h41 + off;
    if (r < 52) return 8'h61 + off - 8'd26;
    if (r < 62) return 8'h30 + off - 8'd52;
    return SPACE_CODE;
  endfunction

  task automatic play_phase(input int unsigned dot, input int unsigned dash,
                            input int unsigned target, input logic calm);
    int unsigned goal;
    int unsigned full;
    int unsigned n;
    int unsigned r;
    drain_status();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DOT_TICKS;
    cfg_data_i <= 16'(dot);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DASH_TICKS;
    cfg_data_i <= 16'(dash);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quiet = calm;
    goal  = busy_items + target;
    full  = 5 * (dot + dash) + dash + 4;
    if (full > 60) full = 60;
    while (busy_items < goal) begin
      r = $urandom_range(99);
      if (r < 80) begin
        push_item(KIND_SEND, pick_char(), 1'b0, '0);
        n = ($urandom_range(3) == 0) ? $urandom_range(full) : full;
        repeat (n) push_tick();
      end else if (r < 90) begin
        push_item(KIND_SEND, 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(5, 1)) push_tick();
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned i;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_DOT_TICKS;
    cfg_data_i      <= '0;
    in_if.valid     <= 1'b0;
    in_if.kind      <= KIND_TICK;
    in_if.char_code <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < DIR_COUNT; i++)
      push_item(DIR_ROWS[i].kind, DIR_ROWS[i].code, DIR_ROWS[i].fixed, DIR_ROWS[i].val);
    play_phase(1, 1, 300, 1'b0);
    play_phase(65535, 65535, 40, 1'b0);
    play_phase(1, 65535, 60, 1'b0);
    play_phase(65535, 1, 60, 1'b0);
    for (i = 0; i < 5; i++)
      play_phase($urandom_range(4, 1), $urandom_range(8, 1), 140, i == 2);
    drain_status();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

endmodule : morse_keyer_core_test

### morse_keyer_core.f
rtl/core/mk_pkg.sv
rtl/core/mk_if.sv
rtl/core/morse_keyer_core.sv
tb/morse_keyer_core_test.sv
